[hw/rtl/scfc_pkg.sv]
// ----------------------------------------------------------------------------
// scfc_pkg
// Shared types and constants for the serial command frame checker.
// ----------------------------------------------------------------------------
package scfc_pkg;

  localparam int unsigned MAX_FRAME_DEF  = 4096;
  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] START_MARK = 8'h01;

  typedef enum logic [1:0] {
    V_OK        = 2'd0,
    V_BAD_START = 2'd1,
    V_TOO_LONG  = 2'd2,
    V_BAD_SUM   = 2'd3
  } verdict_t;

  // Role of one byte within a frame, decided by the front part.
  typedef enum logic [3:0] {
    KIND_START,
    KIND_CMD,
    KIND_STATUS,
    KIND_LEN_LO,
    KIND_LEN_HI_OK,
    KIND_LEN_HI_BAD_START,
    KIND_LEN_HI_TOO_LONG,
    KIND_BODY,
    KIND_SUM_LO,
    KIND_SUM_HI
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

endpackage

[hw/rtl/serial_command_frame_checker.sv]
// ----------------------------------------------------------------------------
// serial_command_frame_checker
// Checks command frames in a received byte stream, one verdict per frame.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room; one verdict per frame: a
// 5-byte header (start 0x01, command, status, 16-bit little-endian length L),
// L payload bytes, then a 16-bit little-endian additive checksum. A bad start
// byte or a frame length L+7 above MAX_FRAME is reported at the last header
// byte and the block goes back to hunting; otherwise ok or checksum mismatch
// is reported at the frame's last byte. Bytes enter without bubbles while
// the queue has room: the front part tags each with its frame role from a
// position counter, a two-entry queue carries it, and the back part adds
// header and payload bytes into the running sum and registers the verdict.
// While the output is free a verdict is registered once its last byte has
// passed the queue, and stays there until taken; bytes keep flowing while
// it waits, until the byte that carries the next verdict reaches the back
// part and the queue behind it fills.
// ----------------------------------------------------------------------------
module serial_command_frame_checker #(
  parameter int unsigned MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [7:0]  command_code,
  output logic [7:0]  status_code,
  output logic [15:0] payload_length
);
  import scfc_pkg::*;

  // front -> queue
  logic   push_valid, push_ready;
  entry_t push_data;
  // queue -> back
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  scfc_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  scfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back part holds the output register; a pending verdict holds back only
  // the next verdict-bearing byte, header and body bytes keep draining.
  scfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .command_code   (command_code),
    .status_code    (status_code),
    .payload_length (payload_length)
  );

endmodule

[hw/rtl/scfc_front.sv]
// ----------------------------------------------------------------------------
// scfc_front
// Tracks the byte position in the frame and tags each byte with its role.
// ----------------------------------------------------------------------------
module scfc_front #(
  parameter int unsigned MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output scfc_pkg::entry_t push_data
);
  import scfc_pkg::*;

  localparam logic [15:0] POS_HUNT   = 16'd0;
  localparam logic [15:0] POS_CMD    = 16'd1;
  localparam logic [15:0] POS_STATUS = 16'd2;
  localparam logic [15:0] POS_LEN_LO = 16'd3;
  localparam logic [15:0] POS_LEN_HI = 16'd4;

  logic [15:0] pos, pos_next;
  logic [15:0] last_pos, last_pos_next;
  logic        start_ok, start_ok_next;
  logic [7:0]  len_lo, len_lo_next;
  kind_t       kind;
  logic [15:0] len_full;
  logic [16:0] total;
  logic        accept;

  assign accept     = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign len_full   = {rx_byte, len_lo};
  assign total      = {1'b0, len_full} + 17'(FRAME_OVERHEAD);

  always_comb begin
    pos_next      = pos + 16'd1;
    last_pos_next = last_pos;
    start_ok_next = start_ok;
    len_lo_next   = len_lo;
    case (pos)
      POS_HUNT: begin
        kind          = KIND_START;
        start_ok_next = (rx_byte == START_MARK);
      end
      POS_CMD:    kind = KIND_CMD;
      POS_STATUS: kind = KIND_STATUS;
      POS_LEN_LO: begin
        kind        = KIND_LEN_LO;
        len_lo_next = rx_byte;
      end
      POS_LEN_HI: begin
        // total fits 17 bits, so a 16-bit wrap also lands above the limit
        if (!start_ok) begin
          kind     = KIND_LEN_HI_BAD_START;
          pos_next = POS_HUNT;
        end else if (total > 17'(MAX_FRAME)) begin
          kind     = KIND_LEN_HI_TOO_LONG;
          pos_next = POS_HUNT;
        end else begin
          kind          = KIND_LEN_HI_OK;
          last_pos_next = len_full + 16'(FRAME_OVERHEAD - 1);
        end
      end
      default: begin
        if (pos == last_pos) begin
          kind     = KIND_SUM_HI;
          pos_next = POS_HUNT;
        end else if (pos == last_pos - 16'd1) begin
          kind = KIND_SUM_LO;
        end else begin
          kind = KIND_BODY;
        end
      end
    endcase
  end

  assign push_data.kind = kind;
  assign push_data.data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HUNT;
      start_ok <= 1'b0;
      last_pos <= '0;
      len_lo   <= '0;
    end else if (accept) begin
      pos      <= pos_next;
      start_ok <= start_ok_next;
      last_pos <= last_pos_next;
      len_lo   <= len_lo_next;
    end
  end

endmodule

[hw/rtl/scfc_queue.sv]
// ----------------------------------------------------------------------------
// scfc_queue
// Short FIFO of tagged bytes between the front and back parts.
// ----------------------------------------------------------------------------
module scfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  scfc_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output scfc_pkg::entry_t pop_data
);
  import scfc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

[hw/rtl/scfc_back.sv]
// ----------------------------------------------------------------------------
// scfc_back
// Keeps header fields and running sum, and registers each verdict.
// ----------------------------------------------------------------------------
module scfc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  scfc_pkg::entry_t pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       verdict,
  output logic [7:0]       command_code,
  output logic [7:0]       status_code,
  output logic [15:0]      payload_length
);
  import scfc_pkg::*;

  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [7:0]  status_byte, status_byte_next;
  logic [15:0] declared_length, declared_length_next;
  logic [7:0]  checksum_low, checksum_low_next;
  logic        emit;
  verdict_t    emit_verdict;
  logic        take;
  logic [15:0] sum_add;

  // only a byte that carries a verdict waits for the output register
  assign pop_ready = !emit || !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign sum_add   = running_sum + {8'd0, pop_data.data};

  always_comb begin
    running_sum_next     = sum_add;
    command_byte_next    = command_byte;
    status_byte_next     = status_byte;
    declared_length_next = declared_length;
    checksum_low_next    = checksum_low;
    emit                 = 1'b0;
    emit_verdict         = V_OK;
    case (pop_data.kind)
      KIND_START:  running_sum_next = {8'd0, pop_data.data};
      KIND_CMD:    command_byte_next = pop_data.data;
      KIND_STATUS: status_byte_next = pop_data.data;
      KIND_LEN_LO: declared_length_next[7:0] = pop_data.data;
      KIND_LEN_HI_OK: declared_length_next[15:8] = pop_data.data;
      KIND_LEN_HI_BAD_START: begin
        declared_length_next[15:8] = pop_data.data;
        emit         = 1'b1;
        emit_verdict = V_BAD_START;
      end
      KIND_LEN_HI_TOO_LONG: begin
        declared_length_next[15:8] = pop_data.data;
        emit         = 1'b1;
        emit_verdict = V_TOO_LONG;
      end
      KIND_BODY: ;
      KIND_SUM_LO: begin
        running_sum_next  = running_sum;
        checksum_low_next = pop_data.data;
      end
      KIND_SUM_HI: begin
        running_sum_next = running_sum;
        emit             = 1'b1;
        emit_verdict     = ({pop_data.data, checksum_low} == running_sum) ? V_OK : V_BAD_SUM;
      end
      default: running_sum_next = running_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      running_sum     <= running_sum_next;
      command_byte    <= command_byte_next;
      status_byte     <= status_byte_next;
      declared_length <= declared_length_next;
      checksum_low    <= checksum_low_next;
    end
    if (take && emit) begin
      verdict        <= emit_verdict;
      command_code   <= command_byte_next;
      status_code    <= status_byte_next;
      payload_length <= declared_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/scfc_checker.sv]
// ----------------------------------------------------------------------------
// scfc_port_checks
// Port-level checks for the serial command frame checker.
// ----------------------------------------------------------------------------
module scfc_port_checks #(
  parameter int unsigned MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [15:0] payload_length
);
  import scfc_pkg::*;

  logic [16:0] frame_total;
  assign frame_total = {1'b0, payload_length} + 17'(FRAME_OVERHEAD);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(payload_length))
    else $error("result dropped or changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_too_long_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == V_TOO_LONG |-> frame_total > 17'(MAX_FRAME))
    else $error("too long reported for a frame within the limit");

  a_full_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == V_OK || verdict == V_BAD_SUM) |-> frame_total <= 17'(MAX_FRAME))
    else $error("checksum verdict for a frame above the limit");

endmodule

bind serial_command_frame_checker scfc_port_checks #(.MAX_FRAME(MAX_FRAME)) u_scfc_checker (.*);

[tb/scfc_checker.sv]
// ----------------------------------------------------------------------------
// scfc_checker
// Watches both channels of the frame checker, predicts and compares verdicts.
// ----------------------------------------------------------------------------
// Every byte taken on the input channel goes through a local frame tracker.
// Each verdict that the tracker produces is queued. Each item taken on the
// output channel is compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module scfc_checker #(
  parameter int unsigned MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  verdict,
  input  logic [7:0]  command_code,
  input  logic [7:0]  status_code,
  input  logic [15:0] payload_length,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import scfc_pkg::*;

  localparam int unsigned HEADER_LEN = 5;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  command;
    logic [7:0]  status;
    logic [15:0] length;
  } frame_report_t;

  frame_report_t expected_reports[$];
  int unsigned   error_total = 0;

  // Frame tracker state
  logic [15:0] frame_pos;
  logic [15:0] frame_sum;
  bit          start_seen;
  logic [7:0]  hdr_cmd;
  logic [7:0]  hdr_status;
  logic [15:0] hdr_len;
  logic [7:0]  sum_lo;

  // Ends the current frame: back to the header hunt.
  function automatic frame_report_t close_frame(verdict_t v);
    frame_report_t r;
    r.verdict  = v;
    r.command  = hdr_cmd;
    r.status   = hdr_status;
    r.length   = hdr_len;
    frame_pos  = '0;
    frame_sum  = '0;
    return r;
  endfunction

  task automatic track_frame_byte(input logic [7:0] b, output bit reported,
                                  output frame_report_t rpt);
    int unsigned total;
    reported = 1'b0;
    rpt      = '0;
    total    = hdr_len + FRAME_OVERHEAD;
    if (frame_pos < HEADER_LEN) begin
      case (frame_pos)
        16'd0: begin
          start_seen = (b == START_MARK);
          frame_sum  = '0;
        end
        16'd1: hdr_cmd = b;
        16'd2: hdr_status = b;
        16'd3: hdr_len[7:0] = b;
        default: hdr_len[15:8] = b;
      endcase
      frame_sum = frame_sum + 16'(b);
      if (frame_pos == HEADER_LEN - 1) begin
        total = hdr_len + FRAME_OVERHEAD;
        // bad start wins over too long
        if (!start_seen) begin
          rpt = close_frame(V_BAD_START);
          reported = 1'b1;
        end else if (total > 32'hFFFF || total > MAX_FRAME) begin
          rpt = close_frame(V_TOO_LONG);
          reported = 1'b1;
        end
      end
      if (!reported) frame_pos = frame_pos + 16'd1;
    end else if (frame_pos < total - 2) begin
      frame_sum = frame_sum + 16'(b);
      frame_pos = frame_pos + 16'd1;
    end else if (frame_pos == total - 2) begin
      sum_lo    = b;
      frame_pos = frame_pos + 16'd1;
    end else begin
      rpt = close_frame(({b, sum_lo} == frame_sum) ? V_OK : V_BAD_SUM);
      reported = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t exp_r;
    frame_report_t new_r;
    bit            got;
    if (rst) begin
      frame_pos  = '0;
      frame_sum  = '0;
      start_seen = 1'b0;
      hdr_cmd    = '0;
      hdr_status = '0;
      hdr_len    = '0;
      sum_lo     = '0;
      expected_reports.delete();
    end else begin
      // output first: a verdict never leaves in the cycle its last byte enters
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected verdict %0d, cmd %0h, status %0h, length %0d",
                 verdict, command_code, status_code, payload_length);
          error_total++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (verdict !== exp_r.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_r.verdict, verdict);
            error_total++;
          end
          if (command_code !== exp_r.command) begin
            $error("command_code: expected %0h, actual %0h", exp_r.command,
                   command_code);
            error_total++;
          end
          if (status_code !== exp_r.status) begin
            $error("status_code: expected %0h, actual %0h", exp_r.status,
                   status_code);
            error_total++;
          end
          if (payload_length !== exp_r.length) begin
            $error("payload_length: expected %0d, actual %0d", exp_r.length,
                   payload_length);
            error_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        track_frame_byte(rx_byte, got, new_r);
        if (got) expected_reports.push_back(new_r);
      end
    end
    mismatches  <= error_total;
    outstanding <= expected_reports.size();
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the serial command frame checker.
// ----------------------------------------------------------------------------
// Feeds the block a byte stream: a few hand-built frames covering each
// verdict and the length and checksum edges, then random frames mixed with
// broken headers and stray bytes. Both channels idle at random. The checker
// module beside the block does all prediction and comparison; this module
// only counts on its results.
// ----------------------------------------------------------------------------
module tb_top;
  import scfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LIMIT  = MAX_FRAME_DEF;
  localparam int unsigned RANDOM_BYTES = 1760;
  localparam int unsigned DRAIN_CYCLES = 16;

  // payload fill patterns
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  verdict;
  logic [7:0]  command_code;
  logic [7:0]  status_code;
  logic [15:0] payload_length;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent = 0;
  bit          burst_mode = 1'b0;  // both sides run without gaps while set

  always #2 clk = ~clk;

  serial_command_frame_checker #(
    .MAX_FRAME (FRAME_LIMIT)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .command_code   (command_code),
    .status_code    (status_code),
    .payload_length (payload_length)
  );

  scfc_checker #(
    .MAX_FRAME (FRAME_LIMIT)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .command_code   (command_code),
    .status_code    (status_code),
    .payload_length (payload_length),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // One byte per item. A gap lowers valid first; with no gap valid stays high
  // and only the byte changes, so valid gets one assignment per edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Five header bytes; returns their 16-bit sum for the checksum.
  task automatic send_header(input logic [7:0] start, input logic [7:0] cmd,
                             input logic [7:0] stat, input logic [15:0] len,
                             output logic [15:0] sum);
    sum = 16'(start) + 16'(cmd) + 16'(stat) + 16'(len[7:0]) + 16'(len[15:8]);
    send_byte(start);
    send_byte(cmd);
    send_byte(stat);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  // Full frame with a good start byte; a nonzero flip corrupts the checksum.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] stat,
                            input logic [15:0] len, input fill_t fill,
                            input logic [15:0] flip);
    logic [15:0] sum;
    logic [15:0] csum;
    logic [7:0]  b;
    send_header(START_MARK, cmd, stat, len, sum);
    for (int i = 0; i < int'(len); i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom);
      endcase
      sum = sum + 16'(b);
      send_byte(b);
    end
    csum = sum ^ flip;
    send_byte(csum[7:0]);
    send_byte(csum[15:8]);
  endtask

  // Output side: a random stall before each verdict is taken.
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [15:0] hsum;
    logic [7:0]  start;
    logic [15:0] len;
    logic [15:0] flip;
    int unsigned pick;
    int unsigned target;
    fill_t       fill;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // empty payload, good checksum
    send_frame(8'h00, 8'h00, 16'd0, FILL_ZEROS, 16'h0000);
    // bad start byte together with a too-long length: bad start wins
    send_header(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, hsum);
    // zero start byte, small length: bad start alone
    send_header(8'h00, 8'h5A, 8'hA5, 16'd3, hsum);
    // one past the frame limit
    send_header(START_MARK, 8'h12, 8'h34, 16'(FRAME_LIMIT - FRAME_OVERHEAD + 1), hsum);
    // length wraps 16 bits once the overhead is added
    send_header(START_MARK, 8'hAA, 8'h55, 16'hFFF9, hsum);
    // one payload byte, checksum off by the top bit
    send_frame(8'hFF, 8'hFF, 16'd1, FILL_ONES, 16'h8000);

    // --- random ---
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      burst_mode = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // well-formed frame, mostly short
        len  = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 24))
                                          : 16'($urandom_range(25, 300));
        case ($urandom_range(0, 5))
          0:       fill = FILL_ONES;
          1:       fill = FILL_ZEROS;
          default: fill = FILL_RANDOM;
        endcase
        flip = 16'h0000;
        if ($urandom_range(0, 5) == 0) begin
          flip = 16'($urandom);
          if (flip == 16'h0000) flip = 16'h0001;
        end
        send_frame(8'($urandom), 8'($urandom), len, fill, flip);
      end else if (pick < 80) begin
        // header with a wrong start byte
        start = 8'($urandom);
        if (start == START_MARK) start = 8'h00;
        send_header(start, 8'($urandom), 8'($urandom), 16'($urandom), hsum);
      end else if (pick < 90) begin
        // header over the limit, edges around the limit and the wrap
        case ($urandom_range(0, 3))
          0:       len = 16'(FRAME_LIMIT - FRAME_OVERHEAD + 1);
          1:       len = 16'($urandom_range(16'hFFF9, 16'hFFFF));
          default: len = 16'($urandom_range(FRAME_LIMIT - FRAME_OVERHEAD + 1, 16'hFFFF));
        endcase
        send_header(START_MARK, 8'($urandom), 8'($urandom), len, hsum);
      end else begin
        // stray bytes: knock the stream off frame alignment
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
    burst_mode = 1'b0;

    // last byte taken: release the input and let the verdicts drain; the
    // count from the checker is registered, so it trails the checker's queue
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
